@@ hdl/tsfc_pkg.sv @@
// package for the turn-signal flasher controller
// holds transfer payload types, side and register codes, brightness scaling
// no dependencies
package tsfc_pkg;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  typedef enum logic [1:0] {
    CFG_BLINK_PERIOD = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_BRIGHTNESS   = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] BlinkPeriodRst = 16'd500;
  localparam logic [15:0] DebounceRst    = 16'd120;
  localparam logic [6:0]  BrightnessRst  = 7'd20;
  localparam logic [6:0]  PercentMax     = 7'd100;
  localparam logic [7:0]  LevelMax       = 8'd255;

  // reciprocal of 100 scaled by 2^19, exact for products below 2^15
  localparam logic [12:0] Recip100       = 13'd5243;

  localparam logic [7:0] CharUpperL = 8'h4C;
  localparam logic [7:0] CharLowerL = 8'h6C;
  localparam logic [7:0] CharUpperR = 8'h52;
  localparam logic [7:0] CharLowerR = 8'h72;
  localparam logic [7:0] CharZero   = 8'h30;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic        left_paddle;
    logic        right_paddle;
    logic [7:0]  host_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] left_level;
    logic [7:0] right_level;
    logic       left_lit;
    logic       right_lit;
    logic       announce;
  } out_item_t;

  // 255 * pct / 100, saturating at 255
  function automatic logic [7:0] brightness_level(input logic [6:0] pct);
    logic [14:0] scaled;
    logic [27:0] prod;
    begin
      scaled = {pct, 8'd0} - {8'd0, pct};
      prod   = 28'(scaled) * 28'(Recip100);
      if (pct > PercentMax) begin
        brightness_level = LevelMax;
      end else begin
        brightness_level = prod[26:19];
      end
    end
  endfunction

endpackage

@@ hdl/turn_signal_flasher_controller_core.sv @@
// turn-signal flasher controller, top level
// input register, single-pass update logic and result register
// depends on tsfc_pkg
//
// usage:
//   items arrive on the in channel (valid/ready); a poll (cmd = 0) carries a
//   timestamp and paddle samples, a host command (cmd = 1) carries a byte
//   selecting left, right or off. only polls produce a result on the out
//   channel (valid/ready): both lamp levels, lit flags and an announce flag.
//   an item is held in the input register until it advances; its state update
//   and result are written at the edge at which it advances, so a poll's result
//   is offered from the result register, which follows the input register.
//   one item per cycle is sustained while the receiver takes results; the update
//   logic is a single pass of one subtract and compare per timer.
//   when the receiver stalls, a held result blocks only a following poll;
//   commands still pass through. reset clears all mode and timer state and
//   loads the default blink period, debounce window and brightness.
//   configuration writes take effect at the next edge and need no handshake.
module turn_signal_flasher_controller_core
  import tsfc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o
);

  typedef logic [TIME_BITS-1:0] time_t;

  logic [15:0] blink_period_q;
  logic [15:0] debounce_q;
  logic [6:0]  brightness_q;

  logic      s1_valid_q;
  in_item_t  s1_data_q;
  logic      s1_adv;
  logic      s1_poll_adv;

  side_e     side_q, side_d;
  logic      left_on_q, left_on_d;
  logic      right_on_q, right_on_d;
  logic [1:0] was_q, was_d;
  time_t     last_toggle_q, last_toggle_d;
  time_t     last_press_q, last_press_d;
  logic      ann_left_q, ann_right_q, ever_q;
  logic      announce;

  logic      out_valid_q;
  out_item_t out_data_q;
  logic [7:0] level;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q <= BlinkPeriodRst;
      debounce_q     <= DebounceRst;
      brightness_q   <= BrightnessRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_BLINK_PERIOD: blink_period_q <= cfg_wdata_i;
        CFG_DEBOUNCE:     debounce_q     <= cfg_wdata_i;
        CFG_BRIGHTNESS:   brightness_q   <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign s1_adv      = s1_valid_q && (s1_data_q.cmd || !out_valid_q || out_ready_i);
  assign s1_poll_adv = s1_adv && !s1_data_q.cmd;
  assign in_ready_o  = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // single-pass update
  always_comb begin
    time_t  now;
    time_t  el_press;
    time_t  el_toggle;
    side_e  want;
    logic   press_l;
    logic   press_r;
    logic   sel;

    now       = TIME_BITS'(s1_data_q.now_ms);
    side_d        = side_q;
    left_on_d     = left_on_q;
    right_on_d    = right_on_q;
    was_d         = was_q;
    last_toggle_d = last_toggle_q;
    last_press_d  = last_press_q;
    want      = side_q;
    sel       = 1'b0;
    press_l   = 1'b0;
    press_r   = 1'b0;
    el_press  = now - last_press_q;
    el_toggle = '0;

    if (s1_data_q.cmd) begin
      case (s1_data_q.host_char)
        CharUpperL, CharLowerL: begin
          want = SIDE_LEFT;
          sel  = 1'b1;
        end
        CharUpperR, CharLowerR: begin
          want = SIDE_RIGHT;
          sel  = 1'b1;
        end
        CharZero: begin
          want = SIDE_NONE;
          sel  = 1'b1;
        end
        default: ;
      endcase
      if (sel && want != side_q) begin
        side_d        = want;
        left_on_d     = (want == SIDE_LEFT);
        right_on_d    = (want == SIDE_RIGHT);
        last_toggle_d = now;
      end
    end else begin
      press_l = s1_data_q.left_paddle && !was_q[0] &&
                (el_press >= TIME_BITS'(debounce_q));
      if (press_l) begin
        last_press_d = now;
        want = (side_q == SIDE_LEFT) ? SIDE_NONE : SIDE_LEFT;
        if (want != side_d) begin
          side_d        = want;
          left_on_d     = (want == SIDE_LEFT);
          right_on_d    = (want == SIDE_RIGHT);
          last_toggle_d = now;
        end
        el_press = '0;
      end
      press_r = s1_data_q.right_paddle && !was_q[1] &&
                (el_press >= TIME_BITS'(debounce_q));
      if (press_r) begin
        last_press_d = now;
        want = (side_d == SIDE_RIGHT) ? SIDE_NONE : SIDE_RIGHT;
        if (want != side_d) begin
          side_d        = want;
          left_on_d     = (want == SIDE_LEFT);
          right_on_d    = (want == SIDE_RIGHT);
          last_toggle_d = now;
        end
      end
      was_d = {s1_data_q.right_paddle, s1_data_q.left_paddle};

      el_toggle = now - last_toggle_d;
      if (side_d != SIDE_NONE && el_toggle >= TIME_BITS'(blink_period_q)) begin
        last_toggle_d = now;
        if (side_d == SIDE_LEFT) begin
          left_on_d  = !left_on_d;
          right_on_d = 1'b0;
        end else begin
          right_on_d = !right_on_d;
          left_on_d  = 1'b0;
        end
      end
    end
  end

  assign announce = !ever_q || (ann_left_q != left_on_d) || (ann_right_q != right_on_d);
  assign level    = brightness_level(brightness_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q        <= SIDE_NONE;
      left_on_q     <= 1'b0;
      right_on_q    <= 1'b0;
      was_q         <= '0;
      last_toggle_q <= '0;
      last_press_q  <= '0;
      ann_left_q    <= 1'b0;
      ann_right_q   <= 1'b0;
      ever_q        <= 1'b0;
    end else if (s1_adv) begin
      side_q        <= side_d;
      left_on_q     <= left_on_d;
      right_on_q    <= right_on_d;
      was_q         <= was_d;
      last_toggle_q <= last_toggle_d;
      last_press_q  <= last_press_d;
      if (s1_poll_adv && announce) begin
        ann_left_q  <= left_on_d;
        ann_right_q <= right_on_d;
        ever_q      <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_poll_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_poll_adv) begin
      out_data_q.left_level  <= left_on_d ? level : 8'd0;
      out_data_q.right_level <= right_on_d ? level : 8'd0;
      out_data_q.left_lit    <= left_on_d;
      out_data_q.right_lit   <= right_on_d;
      out_data_q.announce    <= announce;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_one_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.left_lit && out_data_o.right_lit))
    else $error("both lamps lit");

  a_dark_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.left_lit && !out_data_o.right_lit) |->
      (out_data_o.left_level == 8'd0 && out_data_o.right_level == 8'd0))
    else $error("unlit lamp driven");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_q == SIDE_NONE) |-> (!left_on_q && !right_on_q))
    else $error("lamp lit with no side active");

  a_first_announce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_poll_adv && !ever_q) |=> (out_valid_o && out_data_o.announce))
    else $error("first poll not announced");
`endif

endmodule
